// ===== sv/fpmd_pkg.sv =====
`timescale 1ns / 1ps
package fpmd_pkg;

  localparam logic [1:0] OP_MUL    = 2'd0;
  localparam logic [1:0] OP_DIV    = 2'd1;
  localparam logic [1:0] OP_FACT   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OVER   = 2'd1;
  localparam logic [1:0] ST_UNDER  = 2'd2;
  localparam logic [1:0] ST_BADARG = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic fact_init;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic finish;
    logic fact_next;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_arg;
    logic is_fact;
    logic div_last;
    logic fact_done;
    logic res_ok;
    logic rem_nz;
    logic fact_zero;
  } dp_sts_t;

endpackage

// ===== sv/fpmd_datapath.sv =====
`timescale 1ns / 1ps
module fpmd_datapath import fpmd_pkg::*; #(
  parameter int SCALE = 1000
) (
  input  logic      clk,
  input  in_item_t  item,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t res
);

  localparam logic [63:0] SCALE_U = 64'(SCALE);

  logic [1:0]   op_r;
  logic [63:0]  a_r, b_r;
  logic [63:0]  x_r, y_r, z_r;
  logic         neg_r;
  logic [127:0] prod_r, prod_nxt;
  logic [127:0] q_r;
  logic [63:0]  rem_r;
  logic [6:0]   cnt_r;
  logic [63:0]  i_r;
  logic [63:0]  val_r;
  logic [1:0]   st_r;
  logic [63:0]  mx, my, mz;
  logic [64:0]  rem_sh;
  logic         sub_ok;
  logic         qz, neg_eff;
  logic [63:0]  rval;
  logic [1:0]   rst_st;

  assign mx = x_r[63] ? 64'd0 - x_r : x_r;
  assign my = y_r[63] ? 64'd0 - y_r : y_r;
  assign mz = z_r[63] ? 64'd0 - z_r : z_r;

  // Four 32x32 partial products, one added per mul_step
  logic [1:0]  pp_r;
  logic [31:0] px, py;
  logic [63:0] pp;
  assign px = pp_r[0] ? mx[63:32] : mx[31:0];
  assign py = pp_r[1] ? my[63:32] : my[31:0];
  assign pp = px * py;
  assign prod_nxt = prod_r + ({64'd0, pp} << (7'(pp_r[0]) * 7'd32 + 7'(pp_r[1]) * 7'd32));

  assign rem_sh = {rem_r, prod_r[127]};
  assign sub_ok = rem_sh[64] || (rem_sh[63:0] >= mz);

  assign qz = (q_r == 128'd0);
  assign neg_eff = neg_r && !qz;
  assign rval = neg_eff ? 64'd0 - q_r[63:0] : q_r[63:0];
  always_comb begin
    if (neg_eff) begin
      rst_st = (q_r[127:64] != 64'd0 || q_r[63:0] > 64'h8000_0000_0000_0000) ? ST_UNDER : ST_OK;
    end else begin
      rst_st = (q_r[127:64] != 64'd0 || q_r[63]) ? ST_OVER : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= item.opcode;
      a_r  <= item.operand_a;
      b_r  <= item.operand_b;
      x_r  <= item.operand_a;
      y_r  <= (item.opcode == OP_DIV) ? SCALE_U :
              (item.opcode == OP_FACT) ? 64'd1 : item.operand_b;
      z_r  <= (item.opcode == OP_DIV) ? item.operand_b : SCALE_U;
      prod_r <= '0;
      pp_r <= '0;
      val_r <= item.operand_a;
      st_r  <= ST_BADARG;
    end
    if (cmd.fact_init) begin
      x_r   <= SCALE_U;
      y_r   <= SCALE_U;
      z_r   <= SCALE_U;
      i_r   <= SCALE_U;
      val_r <= SCALE_U;
      st_r  <= ST_OK;
      prod_r <= '0;
      pp_r <= '0;
    end
    if (cmd.mul_step) begin
      prod_r <= prod_nxt;
      pp_r   <= pp_r + 2'd1;
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= '0;
      neg_r <= (x_r[63] ^ y_r[63]) ^ z_r[63];
    end
    if (cmd.div_step) begin
      rem_r  <= sub_ok ? rem_sh[63:0] - mz : rem_sh[63:0];
      q_r    <= {q_r[126:0], sub_ok};
      prod_r <= {prod_r[126:0], 1'b0};
      cnt_r  <= cnt_r + 7'd1;
    end
    if (cmd.finish) begin
      val_r <= rval;
      st_r  <= rst_st;
    end
    if (cmd.fact_next) begin
      x_r    <= val_r;
      y_r    <= i_r + SCALE_U;
      i_r    <= i_r + SCALE_U;
      prod_r <= '0;
      pp_r   <= '0;
    end
  end

  always_comb begin
    sts.is_fact   = (op_r == OP_FACT);
    sts.bad_arg   = (op_r == OP_DIV && b_r == 64'd0) || (op_r == OP_UNUSED) ||
                    (op_r == OP_FACT && a_r[63]);
    sts.div_last  = (cnt_r == 7'd127);
    sts.fact_done = (i_r + SCALE_U > a_r) || (i_r + SCALE_U < i_r);
    sts.res_ok    = (st_r == ST_OK);
    sts.rem_nz    = (rem_r != 64'd0);
    sts.fact_zero = (a_r < SCALE_U);
    res.value     = val_r;
    res.status    = st_r;
  end

endmodule

// ===== sv/fpmd_ctrl.sv =====
`timescale 1ns / 1ps
module fpmd_ctrl import fpmd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_MUL, S_DIV, S_FIN, S_NEXT, S_OUT} state_t;

  state_t     state_r;
  logic [1:0] mcnt_r;
  logic       fchk_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    unique case (state_r)
      S_MUL: begin
        cmd.mul_step  = 1'b1;
        cmd.div_start = (mcnt_r == 2'd3);
      end
      S_DIV:  cmd.div_step = 1'b1;
      S_FIN:  cmd.finish = !fchk_r;
      S_NEXT: begin
        if (fchk_r) begin
          cmd.fact_init = !sts.rem_nz;
        end else begin
          cmd.fact_next = sts.is_fact && sts.res_ok && !sts.fact_done;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mcnt_r  <= '0;
      fchk_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_CHECK;
        S_CHECK: begin
          mcnt_r <= '0;
          fchk_r <= sts.is_fact;
          if (sts.bad_arg) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd3) state_r <= S_DIV;
        end
        S_DIV: if (sts.div_last) state_r <= S_FIN;
        S_FIN: state_r <= S_NEXT;
        S_NEXT: begin
          mcnt_r <= '0;
          fchk_r <= 1'b0;
          if (fchk_r) begin
            if (sts.rem_nz || sts.fact_zero) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_MUL;
            end
          end else if (sts.is_fact && sts.res_ok && !sts.fact_done) begin
            state_r <= S_MUL;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/fixed_point_mul_div_factorial_core.sv =====
`timescale 1ns / 1ps
// Channel | Ports                         | Transaction
// in      | in_valid in_ready in_data     | opcode, operand_a, operand_b
// out     | out_valid out_ready out_data  | value, status
// Multiply and divide pass through idle and check, the partial-product steps,
// the restoring divider, and then the finish, next and output states.
// Factorial first runs one pass that checks the argument is a multiple of SCALE,
// then one pass per step until the result overflows or the argument is reached.
// Zero divisor, negative factorial argument or unused opcode go from check straight to output.
// Reset (rst_n low, synchronous) returns the controller to idle.
// The result is held while out_ready is low; no new transaction is taken.
module fixed_point_mul_div_factorial_core import fpmd_pkg::*; #(
  parameter int SCALE = 1000
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fpmd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  fpmd_datapath #(.SCALE(SCALE)) u_dp (
    .clk, .item(in_data), .cmd, .sts, .res(out_data)
  );

endmodule

// ===== sv/fpmd_checker.sv =====
`timescale 1ns / 1ps
module fpmd_checker import fpmd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second transaction taken");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output after reset");

endmodule

bind fixed_point_mul_div_factorial_core fpmd_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
